// File: sv/zoom_to_fov_interpolator_macros.svh
// Assertion macros shared by the checker of the zoom to field-of-view interpolator.
`ifndef ZOOM_TO_FOV_INTERPOLATOR_MACROS_SVH
`define ZOOM_TO_FOV_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define ZFI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst.
`define ZFI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/zfi_pkg.sv
// Types and constants shared by the zoom to field-of-view interpolator modules.
package zfi_pkg;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [9:0] ROWS_RESET = 10'd258;
  localparam int         MIN_ROWS   = 2;

  // The quotient of one interpolation always fits the 16-bit angle.
  localparam int         DIV_CNT_W  = 4;
  localparam logic [3:0] DIV_LAST   = 4'd15;

  typedef struct packed {
    logic        func;
    logic [8:0]  row_number;
    logic [15:0] zoom_point;
    logic [15:0] hfov_point;
    logic [15:0] vfov_point;
    logic [15:0] zoom_reading;
  } req_t;

  typedef struct packed {
    logic [15:0] hfov_angle;
    logic [15:0] vfov_angle;
    logic [8:0]  bracket_row;
    logic        was_interpolated;
  } rsp_t;

  typedef struct packed {
    logic [15:0] zoom;
    logic [15:0] hfov;
    logic [15:0] vfov;
  } row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_DIV,
    ST_STORE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic load_item;
    logic scan_shift;
    logic capture;
    logic interp;
    logic mul_lo;
    logic mul_hi;
    logic sum_load;
    logic div_step;
    logic div_store;
    logic chan;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
  } dp_stat_t;

endpackage

// File: sv/zfi_ctrl.sv
// Controller: handshakes, row scan sequencing and interpolation step sequencing.
module zfi_ctrl #(
  parameter int MAX_ROWS = 512
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  zfi_pkg::req_t           req_data,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  input  logic                    cfg_write,
  input  logic [9:0]              cfg_data,
  output zfi_pkg::dp_cmd_t        cmd,
  input  zfi_pkg::dp_stat_t       stat,
  output logic [$clog2(MAX_ROWS)-1:0] rd_addr,
  output logic [$clog2(MAX_ROWS)-1:0] row
);

  localparam int AW  = $clog2(MAX_ROWS);
  localparam int RNW = ($clog2(MAX_ROWS + 1) > 10) ? $clog2(MAX_ROWS + 1) : 10;

  zfi_pkg::state_t state, state_next;
  logic [9:0]      rows_in_use;
  logic [AW-1:0]   scan_row, scan_row_next;
  logic            chan, chan_next;
  logic [zfi_pkg::DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic            rsp_valid_next;
  logic [RNW-1:0]  rows_ext, rows_clamp;
  logic [AW-1:0]   last_row;
  logic            row_ok;
  logic            interp;

  // Out-of-range row counts act as the nearest legal count.
  always_comb begin
    rows_ext = RNW'(rows_in_use);
    if (rows_ext < RNW'(zfi_pkg::MIN_ROWS)) begin
      rows_clamp = RNW'(zfi_pkg::MIN_ROWS);
    end else if (rows_ext > RNW'(MAX_ROWS)) begin
      rows_clamp = RNW'(MAX_ROWS);
    end else begin
      rows_clamp = rows_ext;
    end
    last_row = AW'(rows_clamp - RNW'(1));
  end

  assign row_ok = (32'(req_data.row_number) < 32'(MAX_ROWS));
  assign interp = (scan_row != '0) && (scan_row != last_row);
  assign row    = scan_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= zfi_pkg::ST_IDLE;
      rows_in_use <= zfi_pkg::ROWS_RESET;
      scan_row    <= '0;
      chan        <= 1'b0;
      div_cnt     <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      scan_row  <= scan_row_next;
      chan      <= chan_next;
      div_cnt   <= div_cnt_next;
      rsp_valid <= rsp_valid_next;
      if (cfg_write) begin
        rows_in_use <= cfg_data;
      end
    end
  end

  always_comb begin
    state_next    = state;
    scan_row_next = scan_row;
    chan_next     = chan;
    div_cnt_next  = div_cnt;
    cmd           = '0;
    cmd.chan      = chan;
    rd_addr       = scan_row + AW'(1);
    req_stall     = (state != zfi_pkg::ST_IDLE);

    unique case (state)
      zfi_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req_data.func == zfi_pkg::FUNC_WRITE) begin
            cmd.wr_en = row_ok;
          end else begin
            cmd.load_item = 1'b1;
            rd_addr       = '0;
            scan_row_next = '0;
            state_next    = zfi_pkg::ST_SCAN;
          end
        end
      end
      zfi_pkg::ST_SCAN: begin
        // The read data in this cycle belongs to scan_row.
        if (stat.hit || (scan_row == last_row)) begin
          cmd.capture = 1'b1;
          cmd.interp  = interp;
          chan_next   = 1'b0;
          state_next  = interp ? zfi_pkg::ST_MUL_LO : zfi_pkg::ST_FINISH;
        end else begin
          cmd.scan_shift = 1'b1;
          scan_row_next  = scan_row + AW'(1);
        end
      end
      zfi_pkg::ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = zfi_pkg::ST_MUL_HI;
      end
      zfi_pkg::ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = zfi_pkg::ST_SUM;
      end
      zfi_pkg::ST_SUM: begin
        cmd.sum_load = 1'b1;
        div_cnt_next = '0;
        state_next   = zfi_pkg::ST_DIV;
      end
      zfi_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == zfi_pkg::DIV_LAST) begin
          state_next = zfi_pkg::ST_STORE;
        end
      end
      zfi_pkg::ST_STORE: begin
        cmd.div_store = 1'b1;
        if (!chan) begin
          chan_next  = 1'b1;
          state_next = zfi_pkg::ST_MUL_LO;
        end else begin
          state_next = zfi_pkg::ST_FINISH;
        end
      end
      zfi_pkg::ST_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.load_out = 1'b1;
          state_next   = zfi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = zfi_pkg::ST_IDLE;
      end
    endcase
  end

  assign rsp_valid_next = cmd.load_out | (rsp_valid & rsp_stall);

endmodule

// File: sv/zfi_dp.sv
// Datapath: table memory, scan compare, shared multiplier and restoring divider.
module zfi_dp #(
  parameter int MAX_ROWS = 512
) (
  input  logic                    clk,
  input  zfi_pkg::req_t           req_data,
  input  zfi_pkg::dp_cmd_t        cmd,
  output zfi_pkg::dp_stat_t       stat,
  input  logic [$clog2(MAX_ROWS)-1:0] rd_addr,
  input  logic [$clog2(MAX_ROWS)-1:0] row,
  output zfi_pkg::rsp_t           rsp_data
);

  localparam int AW = $clog2(MAX_ROWS);

  zfi_pkg::row_t mem [MAX_ROWS];
  zfi_pkg::row_t rd_q;
  zfi_pkg::row_t prev;
  zfi_pkg::row_t lo;
  zfi_pkg::row_t hi;
  zfi_pkg::row_t wr_row;
  logic [15:0]   reading;
  logic [15:0]   wa;
  logic [15:0]   wb;
  logic [15:0]   span;
  logic [AW-1:0] bracket;
  logic          interp_q;
  logic [15:0]   mul_a;
  logic [15:0]   mul_b;
  logic [31:0]   prod;
  logic [31:0]   acc;
  logic [32:0]   sum;
  logic [16:0]   rem;
  logic [15:0]   quo;
  logic [17:0]   trial;
  logic [17:0]   diff;
  logic          ge;
  logic [15:0]   h_res;
  logic [15:0]   v_res;
  zfi_pkg::rsp_t rsp_q;

  assign wr_row = '{zoom: req_data.zoom_point, hfov: req_data.hfov_point,
                    vfov: req_data.vfov_point};

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[AW'(req_data.row_number)] <= wr_row;
    end
    rd_q <= mem[rd_addr];
  end

  assign stat.hit = (reading <= rd_q.zoom);

  always_comb begin
    if (cmd.mul_hi) begin
      mul_a = cmd.chan ? hi.vfov : hi.hfov;
      mul_b = wb;
    end else begin
      mul_a = cmd.chan ? lo.vfov : lo.hfov;
      mul_b = wa;
    end
  end

  assign sum   = 33'(acc) + 33'(prod);
  assign trial = {rem, quo[15]};
  assign diff  = trial - {2'b00, span};
  assign ge    = (trial >= {2'b00, span});

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      reading <= req_data.zoom_reading;
    end
    if (cmd.scan_shift) begin
      prev <= rd_q;
    end
    if (cmd.capture) begin
      // The bracket row is the current read; the row before it sits in prev.
      lo       <= prev;
      hi       <= rd_q;
      wa       <= rd_q.zoom - reading;
      wb       <= reading - prev.zoom;
      span     <= rd_q.zoom - prev.zoom;
      bracket  <= row;
      interp_q <= cmd.interp;
      h_res    <= rd_q.hfov;
      v_res    <= rd_q.vfov;
    end
    if (cmd.mul_lo || cmd.mul_hi) begin
      prod <= 32'(mul_a) * 32'(mul_b);
    end
    if (cmd.mul_hi) begin
      acc <= prod;
    end
    // The upper half of the sum is below the span, so sixteen steps suffice.
    if (cmd.sum_load) begin
      rem <= sum[32:16];
      quo <= sum[15:0];
    end else if (cmd.div_step) begin
      rem <= ge ? diff[16:0] : trial[16:0];
      quo <= {quo[14:0], ge};
    end
    if (cmd.div_store) begin
      if (cmd.chan) begin
        v_res <= quo;
      end else begin
        h_res <= quo;
      end
    end
    if (cmd.load_out) begin
      rsp_q <= '{hfov_angle: h_res, vfov_angle: v_res,
                 bracket_row: 9'(bracket), was_interpolated: interp_q};
    end
  end

  assign rsp_data = rsp_q;

endmodule

// File: sv/zoom_to_fov_interpolator.sv
// Zoom to field-of-view interpolator: piecewise linear lookup over a row table.
//
// The req channel carries one beat per item. A write beat (func 0) stores a
// breakpoint and two Q8.8 angles in one table row, gives no result and does
// not hold the req side. A lookup beat (func 1) scans rows from row 0, one row
// per cycle through the table memory's single read port, for the first
// breakpoint not below the reading, and gives one beat on the rsp channel.
// A lookup that returns a row unchanged goes straight to its result; one that
// interpolates first uses the shared multiplier and the one-bit-per-cycle
// divider, which treat the two angles in turn. The next beat is taken in the
// cycle after the result is loaded out.
// req_stall is high while a lookup is in progress. The result register lets a
// new item start while the previous result still waits on rsp_stall; a
// finished lookup holds until that register is free.
// cfg_write with cfg_data sets the number of rows searched (reset 258).
// rst clears the control state and sets the row count back to 258; the table
// contents are undefined until written.
module zoom_to_fov_interpolator #(
  parameter int MAX_ROWS = 512
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  zfi_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output zfi_pkg::rsp_t rsp_data,
  input  logic          cfg_write,
  input  logic [9:0]    cfg_data
);

  localparam int AW = $clog2(MAX_ROWS);

  zfi_pkg::dp_cmd_t  cmd;
  zfi_pkg::dp_stat_t stat;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     row;

  zfi_ctrl #(
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .rd_addr   (rd_addr),
    .row       (row)
  );

  zfi_dp #(
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk      (clk),
    .req_data (req_data),
    .cmd      (cmd),
    .stat     (stat),
    .rd_addr  (rd_addr),
    .row      (row),
    .rsp_data (rsp_data)
  );

endmodule

// File: sv/zfi_checker.sv
// Port-level checker for the zoom to field-of-view interpolator and its bind.
`include "zoom_to_fov_interpolator_macros.svh"

module zfi_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input zfi_pkg::req_t req_data,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input zfi_pkg::rsp_t rsp_data
);

  // A stalled result beat must stay put.
  `ZFI_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp beat changed while stalled")

  // A lookup occupies the block, while a write finishes in its own cycle.
  `ZFI_ASSERT_NEXT(a_lookup_busy, req_valid && !req_stall && (req_data.func == zfi_pkg::FUNC_LOOKUP), req_stall, "lookup accepted without going busy")
  `ZFI_ASSERT_NEXT(a_write_quick, req_valid && !req_stall && (req_data.func == zfi_pkg::FUNC_WRITE), !req_stall, "write beat stalled the next item")

  // A new result only comes out of a lookup in progress.
  `ZFI_ASSERT_NOW(a_rsp_from_work, $rose(rsp_valid), $past(req_stall), "result appeared without a lookup in progress")

  // Row zero is always returned as it stands.
  `ZFI_ASSERT_NOW(a_row0_plain, rsp_valid && (rsp_data.bracket_row == 9'd0), !rsp_data.was_interpolated, "row zero reported as interpolated")

endmodule

bind zoom_to_fov_interpolator zfi_checker u_zfi_checker (.*);

// File: test/zfi_fov_checker.sv
// Checker for the zoom to field-of-view interpolator: tracks the row table and compares results.
module zfi_fov_checker #(
  parameter int MAX_ROWS = 512
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  zfi_pkg::req_t req_data,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  zfi_pkg::rsp_t rsp_data,
  input  logic          cfg_write,
  input  logic [9:0]    cfg_data,
  output int            mismatches,
  output int            angles_owed
);

  zfi_pkg::row_t fov_rows [MAX_ROWS];
  logic [9:0]    rows_setting;
  zfi_pkg::rsp_t fov_due [$];
  int            fail_tally = 0;
  int            owed_count = 0;

  assign mismatches  = fail_tally;
  assign angles_owed = owed_count;

  // Straight-line blend between two neighboring rows, truncated toward zero.
  function automatic logic [15:0] blend_angle(input logic [15:0] a_lo, input logic [15:0] a_hi,
                                              input logic [15:0] z_lo, input logic [15:0] z_hi,
                                              input logic [15:0] reading);
    longint unsigned lo_z, hi_z, pos, width, weighted;
    lo_z     = 64'(z_lo);
    hi_z     = 64'(z_hi);
    pos      = 64'(reading);
    width    = hi_z - lo_z;
    weighted = 64'(a_lo) * (hi_z - pos) + 64'(a_hi) * (pos - lo_z);
    if (width == 0) return a_hi;
    return 16'(weighted / width);
  endfunction

  function automatic zfi_pkg::rsp_t interpolate_fov(input logic [15:0] reading);
    int            rows_searched;
    int            bracket;
    bit            found;
    zfi_pkg::rsp_t fov;
    rows_searched = int'(rows_setting);
    if (rows_searched < zfi_pkg::MIN_ROWS) rows_searched = zfi_pkg::MIN_ROWS;
    if (rows_searched > MAX_ROWS) rows_searched = MAX_ROWS;
    // A reading above every breakpoint lands on the last row in use.
    bracket = rows_searched - 1;
    found   = 1'b0;
    for (int i = 0; i < rows_searched && !found; i++) begin
      if (reading <= fov_rows[i].zoom) begin
        bracket = i;
        found   = 1'b1;
      end
    end
    fov.bracket_row = 9'(bracket);
    if (bracket == 0 || bracket == rows_searched - 1) begin
      fov.hfov_angle       = fov_rows[bracket].hfov;
      fov.vfov_angle       = fov_rows[bracket].vfov;
      fov.was_interpolated = 1'b0;
    end else begin
      fov.hfov_angle       = blend_angle(fov_rows[bracket-1].hfov, fov_rows[bracket].hfov,
                                         fov_rows[bracket-1].zoom, fov_rows[bracket].zoom,
                                         reading);
      fov.vfov_angle       = blend_angle(fov_rows[bracket-1].vfov, fov_rows[bracket].vfov,
                                         fov_rows[bracket-1].zoom, fov_rows[bracket].zoom,
                                         reading);
      fov.was_interpolated = 1'b1;
    end
    return fov;
  endfunction

  function automatic void compare_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_tally++;
    end
  endfunction

  always @(posedge clk) begin : watch
    zfi_pkg::rsp_t want;
    if (rst) begin
      rows_setting = zfi_pkg::ROWS_RESET;
      fov_due.delete();
    end else begin
      if (cfg_write) rows_setting = cfg_data;
      // Results are retired before new lookups are queued on the same edge.
      if (rsp_valid && !rsp_stall) begin
        if (fov_due.size() == 0) begin
          $error("result beat arrived with no lookup outstanding");
          fail_tally++;
        end else begin
          want = fov_due.pop_front();
          compare_field("hfov_angle", want.hfov_angle, rsp_data.hfov_angle);
          compare_field("vfov_angle", want.vfov_angle, rsp_data.vfov_angle);
          compare_field("bracket_row", 16'(want.bracket_row), 16'(rsp_data.bracket_row));
          compare_field("was_interpolated", 16'(want.was_interpolated),
                        16'(rsp_data.was_interpolated));
        end
      end
      if (req_valid && !req_stall) begin
        if (req_data.func == zfi_pkg::FUNC_WRITE) begin
          if (int'(req_data.row_number) < MAX_ROWS)
            fov_rows[req_data.row_number] = '{zoom: req_data.zoom_point,
                                              hfov: req_data.hfov_point,
                                              vfov: req_data.vfov_point};
        end else begin
          fov_due.push_back(interpolate_fov(req_data.zoom_reading));
        end
      end
    end
    owed_count = fov_due.size();
  end

endmodule

// File: test/zoom_to_fov_interpolator_tb.sv
// Testbench top for the zoom to field-of-view interpolator: stimulus, timeout and verdict.
module zoom_to_fov_interpolator_tb;

  localparam int TABLE_ROWS   = 512;
  localparam int HALF_PERIOD  = 6;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int IDLE_PCT     = 29;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  zfi_pkg::req_t req_data  = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  zfi_pkg::rsp_t rsp_data;
  logic          cfg_write = 1'b0;
  logic [9:0]    cfg_data  = '0;
  int            mismatches;
  int            angles_owed;
  int            idle_pct  = IDLE_PCT;
  int            rows_active;
  logic [15:0]   ramp_points [TABLE_ROWS];

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  zoom_to_fov_interpolator #(
    .MAX_ROWS (TABLE_ROWS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  zfi_fov_checker #(
    .MAX_ROWS (TABLE_ROWS)
  ) fov_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_data    (req_data),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp_data    (rsp_data),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .angles_owed (angles_owed)
  );

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < idle_pct);
  end

  function automatic zfi_pkg::req_t random_beat();
    zfi_pkg::req_t beat;
    beat.func         = 1'($urandom);
    beat.row_number   = 9'($urandom);
    beat.zoom_point   = 16'($urandom);
    beat.hfov_point   = 16'($urandom);
    beat.vfov_point   = 16'($urandom);
    beat.zoom_reading = 16'($urandom);
    return beat;
  endfunction

  // Holds the beat until it is taken; the payload never changes while stalled.
  task automatic send_beat(input zfi_pkg::req_t beat);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= beat;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic write_row(input int row, input logic [15:0] zoom, input logic [15:0] hfov,
                           input logic [15:0] vfov);
    zfi_pkg::req_t beat;
    beat            = random_beat();
    beat.func       = zfi_pkg::FUNC_WRITE;
    beat.row_number = 9'(row);
    beat.zoom_point = zoom;
    beat.hfov_point = hfov;
    beat.vfov_point = vfov;
    ramp_points[row] = zoom;
    send_beat(beat);
  endtask

  task automatic lookup_zoom(input logic [15:0] reading);
    zfi_pkg::req_t beat;
    beat              = random_beat();
    beat.func         = zfi_pkg::FUNC_LOOKUP;
    beat.zoom_reading = reading;
    send_beat(beat);
  endtask

  // Fills rows 0 to count-1 with rising breakpoints, each step at most 65000/count.
  task automatic load_ramp(input int count);
    int zoom;
    int stride;
    stride = 65000 / count;
    zoom   = $urandom_range(0, 300);
    for (int row = 0; row < count; row++) begin
      write_row(row, 16'(zoom), 16'($urandom), 16'($urandom));
      zoom = zoom + int'($urandom_range(1, stride));
      if (zoom > 65535) zoom = 65535;
    end
  endtask

  function automatic logic [15:0] pick_reading();
    int unsigned roll;
    int          row;
    roll = $urandom_range(0, 99);
    row  = $urandom_range(0, rows_active - 1);
    if (roll < 55) return 16'($urandom_range(ramp_points[0], ramp_points[rows_active - 1]));
    if (roll < 75) return ramp_points[row];
    if (roll < 82) return ramp_points[row] + 16'd1;
    if (roll < 88) return 16'($urandom_range(0, ramp_points[0]));
    if (roll < 94) return 16'($urandom_range(ramp_points[rows_active - 1], 65535));
    return 16'($urandom);
  endfunction

  // Drops valid, waits for every lookup to come back, then lets the block drain.
  task automatic settle(input int drain_cycles);
    req_valid <= 1'b0;
    do @(negedge clk); while (angles_owed != 0);
    repeat (drain_cycles) @(posedge clk);
  endtask

  task automatic set_rows(input logic [9:0] value);
    settle(4);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    rows_active = int'(value);
    if (rows_active < zfi_pkg::MIN_ROWS) rows_active = zfi_pkg::MIN_ROWS;
    if (rows_active > TABLE_ROWS) rows_active = TABLE_ROWS;
  endtask

  initial begin : stimulus
    logic [9:0] phase_rows [14];
    int         lookups_left;
    phase_rows = '{10'd2, 10'd0, 10'd1, 10'd6, 10'd13, 10'd1023, 10'd32,
                   10'd3, 10'd513, 10'd20, 10'd64, 10'd512, 10'd9, 10'd258};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    rows_active = int'(zfi_pkg::ROWS_RESET);

    // Every row gets written once up front so no lookup ever reads an empty row.
    load_ramp(TABLE_ROWS);
    lookup_zoom(16'h0000);
    lookup_zoom(16'hFFFF);
    lookup_zoom(ramp_points[zfi_pkg::ROWS_RESET - 1]);
    lookup_zoom(ramp_points[zfi_pkg::ROWS_RESET - 1] + 16'd1);
    lookup_zoom(ramp_points[100]);
    lookup_zoom(ramp_points[100] - 16'd1);
    lookup_zoom(ramp_points[0]);

    // Full-scale angles on both ends of an interpolation.
    set_rows(10'd3);
    write_row(0, 16'h0000, 16'h0000, 16'hFFFF);
    write_row(1, 16'h8000, 16'hFFFF, 16'h0000);
    write_row(2, 16'hFFFF, 16'h1234, 16'hFFFF);
    write_row(TABLE_ROWS - 1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    lookup_zoom(16'h0000);
    lookup_zoom(16'h0001);
    lookup_zoom(16'h7FFF);
    lookup_zoom(16'h8000);
    lookup_zoom(16'h8001);
    lookup_zoom(16'hFFFF);

    // A table that is out of order still brackets on the first row not below.
    set_rows(10'd4);
    write_row(0, 16'd100, 16'($urandom), 16'($urandom));
    write_row(1, 16'd50, 16'($urandom), 16'($urandom));
    write_row(2, 16'd200, 16'($urandom), 16'($urandom));
    write_row(3, 16'd60000, 16'($urandom), 16'($urandom));
    lookup_zoom(16'd150);
    lookup_zoom(16'd75);
    lookup_zoom(16'd60000);

    foreach (phase_rows[p]) begin
      set_rows(phase_rows[p]);
      idle_pct = (p == 6) ? 0 : IDLE_PCT;
      // Large tables keep the rows already written and are not reloaded.
      if (rows_active <= 64) load_ramp(rows_active);
      lookups_left = 25;
      while (lookups_left > 0) begin
        if ($urandom_range(0, 99) < 8) begin
          write_row($urandom_range(0, TABLE_ROWS - 1), 16'($urandom), 16'($urandom),
                    16'($urandom));
        end else begin
          lookup_zoom(pick_reading());
          lookups_left--;
        end
      end
    end

    settle(600);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/zfi_pkg.sv
sv/zfi_ctrl.sv
sv/zfi_dp.sv
sv/zoom_to_fov_interpolator.sv
sv/zfi_checker.sv
test/zfi_fov_checker.sv
test/zoom_to_fov_interpolator_tb.sv
